// ===== sv/range_scan_to_cartesian_points_defines.svh =====
// ----------------------------------------------------------------------------
// range scan to cartesian points: assertion macros
// Concurrent checks on clk_i, with and without the reset disable.
// ----------------------------------------------------------------------------
`ifndef RANGE_SCAN_TO_CARTESIAN_POINTS_DEFINES_SVH
`define RANGE_SCAN_TO_CARTESIAN_POINTS_DEFINES_SVH

`ifndef NO_ASSERTIONS
// checked while out of reset
`define RSCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset too
`define RSCP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RSCP_ASSERT(lbl, prop, msg)
`define RSCP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== sv/rscp_pkg.sv =====
// ----------------------------------------------------------------------------
// rscp_pkg
// Constants, register indexes and helpers for the range scan point converter.
// ----------------------------------------------------------------------------
package rscp_pkg;

  localparam int unsigned AngleBitsDefault      = 16;
  localparam int unsigned RotationStagesDefault = 16;
  localparam int unsigned MaxStages             = 24;

  localparam int unsigned RangeW   = 16;
  localparam int unsigned RegW     = 16;
  localparam int unsigned CoordW   = 17;
  localparam int unsigned FracBits = 14;
  localparam int unsigned PhaseW   = 32;
  // datapath width: r / K in Q.14 stays below 2^31 through the rotation
  localparam int unsigned CordicW  = 33;
  localparam int unsigned GainW    = 32;

  // 1/K in Q.32
  localparam logic [GainW-1:0] InvGainQ32 = 32'd2608131496;

  typedef enum logic [1:0] {
    RegAngleStart = 2'd0,
    RegAngleStep  = 2'd1,
    RegRangeMin   = 2'd2,
    RegRangeMax   = 2'd3
  } reg_idx_e;

  localparam logic [1:0] QuadI   = 2'd0;
  localparam logic [1:0] QuadII  = 2'd1;
  localparam logic [1:0] QuadIII = 2'd2;
  localparam logic [1:0] QuadIV  = 2'd3;

  // atan(2^-i) with 2^32 per turn
  localparam logic [PhaseW-1:0] AtanTurns [MaxStages] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam int unsigned MmW = CordicW - FracBits + 1;
  localparam logic signed [MmW-1:0] MmMax = MmW'(65535);
  localparam logic signed [MmW-1:0] MmMin = -MmW'(65535);

  // round Q.14 to mm, saturate to +-65535
  function automatic logic signed [CoordW-1:0] to_mm(input logic signed [CordicW-1:0] v);
    logic signed [CordicW:0] s;
    logic signed [MmW-1:0]   m;
    s = $signed({v[CordicW-1], v}) + $signed((CordicW+1)'(1 << (FracBits - 1)));
    m = s[CordicW:FracBits];
    if (m > MmMax) begin
      m = MmMax;
    end else if (m < MmMin) begin
      m = MmMin;
    end
    return m[CoordW-1:0];
  endfunction

endpackage

// ===== sv/range_scan_to_cartesian_points.sv =====
// ----------------------------------------------------------------------------
// range_scan_to_cartesian_points
// Lidar range samples in, (x, y) points in mm out, by a pipelined CORDIC.
// ----------------------------------------------------------------------------
// One range sample is taken per cycle while s_tready_o is high. A beat with
// scan_start set loads the beam angle from angle_start; each beat then
// advances it by angle_step. Samples that are not finite or fall outside the
// window set by the min and max range registers give no point but still
// advance the angle. A point passes the input register, vector setup (the
// 1/K multiply and quadrant fold), one register per rotation stage, and the
// output register. A two-entry output (register plus skid) lets input keep
// flowing while m_tready_i is low until the skid entry fills; the pipeline
// holds only when the skid entry is full. Config writes take effect at the
// next edge and should be made with the pipeline empty.
`include "range_scan_to_cartesian_points_defines.svh"

module range_scan_to_cartesian_points #(
  parameter int unsigned ANGLE_BITS      = rscp_pkg::AngleBitsDefault,
  parameter int unsigned ROTATION_STAGES = rscp_pkg::RotationStagesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // sample stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [15:0] s_tdata_i,   // [15:0] range_mm
  input  logic [1:0]  s_tuser_i,   // [0] range_finite, [1] scan_start
  // point stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [39:0] m_tdata_o    // [16:0] x_mm, [33:17] y_mm, [39:34] zero
);

  localparam int unsigned CW = rscp_pkg::CordicW;
  localparam int unsigned PW = rscp_pkg::PhaseW;
  localparam int unsigned OW = rscp_pkg::CoordW;
  localparam int unsigned N  = ROTATION_STAGES;

  // 16-bit register pattern to ANGLE_BITS binary angle
  function automatic logic [ANGLE_BITS-1:0] scale_angle(input logic [15:0] r);
    logic [ANGLE_BITS+15:0] ext;
    ext = {r, {ANGLE_BITS{1'b0}}};
    return ext[ANGLE_BITS+15 -: ANGLE_BITS];
  endfunction

  // ---------------------------------------------------------------- config
  logic [15:0] angle_start_q, angle_step_q, win_lo_q, win_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_start_q <= '0;
      angle_step_q  <= '0;
      win_lo_q      <= '0;
      win_hi_q      <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (rscp_pkg::reg_idx_e'(cfg_idx_i))
        rscp_pkg::RegAngleStart: angle_start_q <= cfg_data_i;
        rscp_pkg::RegAngleStep:  angle_step_q  <= cfg_data_i;
        rscp_pkg::RegRangeMin:   win_lo_q      <= cfg_data_i;
        rscp_pkg::RegRangeMax:   win_hi_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- flow control
  logic en;
  logic accept;
  logic skid_valid_q;

  assign en         = !skid_valid_q;
  assign s_tready_o = en;
  assign accept     = s_tvalid_i && en;

  // ------------------------------------------------------ beam angle
  logic [ANGLE_BITS-1:0] beam_angle_q, beam_angle_d, ang_cur;

  always_comb begin
    ang_cur      = s_tuser_i[1] ? scale_angle(angle_start_q) : beam_angle_q;
    beam_angle_d = ang_cur + scale_angle(angle_step_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beam_angle_q <= '0;
    end else if (accept) begin
      beam_angle_q <= beam_angle_d;
    end
  end

  // ------------------------------------------------------ input register
  logic                  in_valid_q;
  logic [15:0]           in_range_q;
  logic [ANGLE_BITS-1:0] in_angle_q;
  logic                  keep;

  assign keep = s_tuser_i[0] && (s_tdata_i >= win_lo_q) && (s_tdata_i <= win_hi_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (en) begin
      in_valid_q <= accept && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_range_q <= s_tdata_i;
      in_angle_q <= ang_cur;
    end
  end

  // ------------------------------------------------------ vector setup
  logic [PW-1:0]                    phase, phase_off, resid;
  logic [1:0]                       quad;
  logic [PW+rscp_pkg::RangeW-1:0]   prod;

  always_comb begin
    phase     = {in_angle_q, {(PW - ANGLE_BITS){1'b0}}};
    phase_off = phase + PW'(32'h20000000);
    quad      = phase_off[PW-1 -: 2];
    resid     = phase - {quad, {(PW - 2){1'b0}}};
    prod      = {{PW{1'b0}}, in_range_q} *
                {{rscp_pkg::RangeW{1'b0}}, rscp_pkg::InvGainQ32};
  end

  logic                 cv_q [N+1];
  logic signed [CW-1:0] cx_q [N+1];
  logic signed [CW-1:0] cy_q [N+1];
  logic signed [PW-1:0] cz_q [N+1];
  logic [1:0]           cq_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0] <= $signed(CW'(prod[PW+rscp_pkg::RangeW-1 : PW-rscp_pkg::FracBits]));
      cy_q[0] <= '0;
      cz_q[0] <= $signed(resid);
      cq_q[0] <= quad;
    end
  end

  // ------------------------------------------------------ rotation stages
  for (genvar k = 0; k < N; k++) begin : g_rot
    logic signed [CW-1:0] dx, dy;
    logic signed [PW-1:0] at;

    assign dx = cy_q[k] >>> k;
    assign dy = cx_q[k] >>> k;
    assign at = $signed(rscp_pkg::AtanTurns[k]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[k+1] <= 1'b0;
      end else if (en) begin
        cv_q[k+1] <= cv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        cq_q[k+1] <= cq_q[k];
        if (!cz_q[k][PW-1]) begin
          cx_q[k+1] <= cx_q[k] - dx;
          cy_q[k+1] <= cy_q[k] + dy;
          cz_q[k+1] <= cz_q[k] - at;
        end else begin
          cx_q[k+1] <= cx_q[k] + dx;
          cy_q[k+1] <= cy_q[k] - dy;
          cz_q[k+1] <= cz_q[k] + at;
        end
      end
    end
  end

  // ------------------------------------------------------ quadrant, rounding
  logic signed [CW-1:0] xo, yo;
  logic signed [OW-1:0] x_mm, y_mm;

  always_comb begin
    case (cq_q[N])
      rscp_pkg::QuadI:   begin xo =  cx_q[N]; yo =  cy_q[N]; end
      rscp_pkg::QuadII:  begin xo = -cy_q[N]; yo =  cx_q[N]; end
      rscp_pkg::QuadIII: begin xo = -cx_q[N]; yo = -cy_q[N]; end
      rscp_pkg::QuadIV:  begin xo =  cy_q[N]; yo = -cx_q[N]; end
      default:           begin xo =  cx_q[N]; yo =  cy_q[N]; end
    endcase
    x_mm = rscp_pkg::to_mm(xo);
    y_mm = rscp_pkg::to_mm(yo);
  end

  // ------------------------------------------------------ output + skid
  logic                 out_valid_q;
  logic signed [OW-1:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
  logic                 pop, push;

  assign pop  = out_valid_q && m_tready_i;
  assign push = en && cv_q[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_x_q <= skid_x_q;
        out_y_q <= skid_y_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_x_q <= x_mm;
        skid_y_q <= y_mm;
      end else begin
        out_x_q <= x_mm;
        out_y_q <= y_mm;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {6'b0, out_y_q, out_x_q};

  // ------------------------------------------------------ checks
  `RSCP_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q,
               "skid entry held without an output beat")
  `RSCP_ASSERT(a_angle_holds_on_stall, !s_tready_o |=> $stable(beam_angle_q),
               "beam angle moved while input was stalled")
  `RSCP_ASSERT(a_coord_saturated,
               out_valid_q |-> (out_x_q != -OW'(65536) && out_y_q != -OW'(65536)),
               "coordinate outside saturation range")
  `RSCP_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_ni |-> !m_tvalid_o,
                      "output beat during reset")

endmodule
